// ----- rtl/mup_pkg.sv -----
// shared types and constants for the midi to usb event packer
package mup_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ONE   = 3'd1,
        PH_D1    = 3'd2,
        PH_D2    = 3'd3,
        PH_SYSEX = 3'd4
    } t_phase;

    // input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // status bytes and status nibbles
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_MTC   = 8'hF1;
    localparam logic [7:0] ST_SPP   = 8'hF2;
    localparam logic [7:0] ST_SONG  = 8'hF3;
    localparam logic [7:0] ST_EOX   = 8'hF7;
    localparam logic [7:0] ST_RESET = 8'hFF;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_POLY_AT  = 4'hA;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
    localparam logic [3:0] NIB_BEND     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // queue between parser and serializer
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] midi_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] usb_byte;
        logic       last_of_run;
        logic       discard_buffer;
    } t_out_item;

    // one queued job: a single byte or a four byte event, first byte in bytes[3]
    typedef struct packed {
        logic            discard;
        logic            four;
        logic [3:0][7:0] bytes;
    } t_job;

endpackage

// ----- rtl/midi_to_usb_event_packer.sv -----
// top level of the midi to usb event packer
//
// input channel: i_valid / o_ready with i_item {cmd, midi_byte}; cmd set means
// the downstream buffer was drained and the fill count goes back to zero
// output channel: o_valid / i_ready with o_item {usb_byte, last_of_run,
// discard_buffer}; one usb byte per beat, last_of_run marks the final beat
// caused by one input beat
// a complete message gives four beats (code, status, data, data or zero), a
// sysex byte gives one beat, each while the fill count leaves room; system
// reset gives one discard beat; beats pass through the job queue and then
// the output register; throughput: one beat per cycle while jobs wait and
// i_ready is high, set by the serializer; a four entry job queue lets the
// parser keep taking input beats while the serializer works; o_ready drops
// only when the queue is full
// when the receiver stalls the output register holds its beat, the queue
// fills and then the input side stalls too; nothing is lost
// reset (synchronous, active low) returns the parser to idle, clears the
// fill count and empties the queue
module midi_to_usb_event_packer import mup_pkg::*; #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // parser to queue
    logic q_push;
    t_job q_job;
    logic q_full;

    // queue to serializer
    logic q_pop;
    logic q_empty;
    t_job q_head;

    mup_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (q_push),
        .o_job    (q_job)
    );

    mup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // serializer owns the output register
    mup_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ----- rtl/mup_front.sv -----
// parser: accepts midi bytes, tracks fill count, builds jobs
module mup_front import mup_pkg::*; #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_ready,
    output logic     o_push,
    output t_job     o_job
);

    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(BUFFER_BYTES);
    localparam logic [FW-1:0] FILL_PKT  = FW'(BUFFER_BYTES - 4);

    t_phase        r_phase,  n_phase;
    logic [7:0]    r_status, n_status;
    logic [3:0]    r_code,   n_code;
    logic [7:0]    r_first,  n_first;
    logic [FW-1:0] r_fill,   n_fill;
    logic          emit;
    t_job          job;
    logic          accept;
    logic [7:0]    b;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.midi_byte;
    assign o_push  = accept && emit;
    assign o_job   = job;

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_code   = r_code;
        n_first  = r_first;
        n_fill   = r_fill;
        emit     = 1'b0;
        job      = '0;
        if (i_item.cmd == CMD_DRAIN) begin
            n_fill = '0;
        end else if (b == ST_RESET) begin
            n_fill      = '0;
            n_phase     = PH_IDLE;
            emit        = 1'b1;
            job.discard = 1'b1;
        end else begin
            case (r_phase)
                PH_D1: begin
                    n_first = b;
                    n_phase = PH_D2;
                end
                PH_D2: begin
                    n_phase = PH_IDLE;
                    if (r_fill <= FILL_PKT) begin
                        emit      = 1'b1;
                        job.four  = 1'b1;
                        job.bytes = {{4'h0, r_code}, r_status, r_first, b};
                        n_fill    = r_fill + FW'(4);
                    end
                end
                PH_ONE: begin
                    n_phase = PH_IDLE;
                    n_first = b;
                    if (r_fill <= FILL_PKT) begin
                        emit      = 1'b1;
                        job.four  = 1'b1;
                        job.bytes = {{4'h0, r_code}, r_status, b, 8'h00};
                        n_fill    = r_fill + FW'(4);
                    end
                end
                PH_SYSEX: begin
                    if (r_fill < FILL_MAX) begin
                        emit         = 1'b1;
                        job.bytes[3] = b;
                        n_fill       = r_fill + FW'(1);
                    end
                    if (b == ST_EOX) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    case (b[7:4])
                        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: begin
                            n_code   = b[7:4];
                            n_status = b;
                            n_phase  = PH_D1;
                        end
                        NIB_PROG, NIB_CHAN_AT: begin
                            n_code   = b[7:4];
                            n_status = b;
                            n_phase  = PH_ONE;
                        end
                        NIB_SYSTEM: begin
                            if (b == ST_SYSEX) begin
                                n_code   = 4'h0;
                                n_status = b;
                                n_phase  = PH_SYSEX;
                                if (r_fill < FILL_MAX) begin
                                    emit         = 1'b1;
                                    job.bytes[3] = b;
                                    n_fill       = r_fill + FW'(1);
                                end
                            end else if (b == ST_MTC || b == ST_SONG) begin
                                n_code   = 4'h0;
                                n_status = b;
                                n_phase  = PH_ONE;
                            end else if (b == ST_SPP) begin
                                n_code   = 4'h0;
                                n_status = b;
                                n_phase  = PH_D1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_status <= '0;
            r_code   <= '0;
            r_first  <= '0;
            r_fill   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_code   <= n_code;
            r_first  <= n_first;
            r_fill   <= n_fill;
        end
    end

endmodule

// ----- rtl/mup_queue.sv -----
// small job queue between parser and serializer
module mup_queue import mup_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/mup_back.sv -----
// serializer: walks the head job one byte per beat into the output register
module mup_back import mup_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_job      i_head,
    output logic      o_pop,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_item o_item
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_item;
    logic       load;
    logic       last;
    t_out_item  n_item;

    assign load  = !i_empty && (!r_valid || i_ready);
    assign last  = !i_head.four || (r_idx == 2'd3);
    assign o_pop = load && last;

    always_comb begin
        n_item.usb_byte       = i_head.bytes[2'd3 - r_idx];
        n_item.last_of_run    = last;
        n_item.discard_buffer = i_head.discard;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/mup_checker.sv -----
// port level checks for the midi to usb event packer
module mup_checker import mup_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_item
);

    // nothing on the output right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_item))
        else $error("input beat changed while waiting");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output beat changed while stalled");

    // discard beat is a lone zero byte
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.discard_buffer |-> o_item.usb_byte == 8'h00 && o_item.last_of_run)
        else $error("malformed discard beat");

    // a run is never broken by a bubble
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_item.last_of_run |=> o_valid)
        else $error("gap inside an output run");

endmodule

bind midi_to_usb_event_packer mup_checker u_mup_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
